// ===== hw/rtl/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg: shared types and constants for the indexed list
// Sizes, command and status codes, and the control word sent to the cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
    localparam int IDX_WIDTH   = $clog2(CAPACITY);
    // signed width for index arithmetic: covers 8-bit position and the count
    localparam int SIDX_WIDTH  = COUNT_WIDTH + 9;

    localparam int CMD_WIDTH    = 2;
    localparam int POS_WIDTH    = 8;
    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int CFIELD_WIDTH = 7;

    typedef logic [DATA_WIDTH-1:0]   data_t;
    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef logic [IDX_WIDTH-1:0]    idx_t;
    typedef logic [CMD_WIDTH-1:0]    cmd_t;
    typedef logic [STATUS_WIDTH-1:0] status_t;
    typedef logic [VALUE_WIDTH-1:0]  value_t;
    typedef logic [CFIELD_WIDTH-1:0] cfield_t;

    localparam cmd_t CMD_APPEND = 2'd0;
    localparam cmd_t CMD_INSERT = 2'd1;
    localparam cmd_t CMD_GET    = 2'd2;
    localparam cmd_t CMD_REMOVE = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t op;
        idx_t     idx;
        data_t    data;
    } cell_ctrl_t;

    // decode result for the output stage
    typedef struct packed {
        status_t status;
        logic    read_en;
        count_t  count_next;
    } cmd_result_t;

endpackage

// ===== hw/rtl/indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove: fixed-capacity ordered list
//
//   port group   dir  word contents
//   s_axis_*     in   command, position, item_value
//   m_axis_*     out  read_value, status, count
//
// One command per cycle while s_axis_tready is high: every slot is a cell that
// shifts toward or away from its neighbor in the same cycle, so the whole list
// moves at once. The result is in the output register in the next cycle.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
// Reset empties the list; element storage itself is not cleared.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] command, [9:2] position, [41:10] item_value, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_value, [33:32] status, [40:34] count, [47:41] zero
    output logic [47:0] m_axis_tdata
);

    localparam int N = ilir_pkg::CAPACITY;

    logic                  accept;
    ilir_pkg::cell_ctrl_t  ctrl;
    ilir_pkg::cmd_result_t result;
    ilir_pkg::data_t       slot_data [N];
    ilir_pkg::data_t       read_data [N];
    ilir_pkg::data_t       read_bus;

    ilir_pkg::count_t  count_reg;
    ilir_pkg::count_t  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    ilir_pkg::value_t  out_value_reg;
    ilir_pkg::value_t  out_value_next;
    ilir_pkg::status_t out_status_reg;
    ilir_pkg::status_t out_status_next;
    ilir_pkg::cfield_t out_count_reg;
    ilir_pkg::cfield_t out_count_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ilir_ctrl u_ctrl (
        .accept     (accept),
        .command    (s_axis_tdata[1:0]),
        .position   ($signed(s_axis_tdata[9:2])),
        .item_value (s_axis_tdata[41:10]),
        .count      (count_reg),
        .ctrl       (ctrl),
        .result     (result)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        ilir_pkg::data_t lower;
        ilir_pkg::data_t upper;
        if (i == 0) begin : g_lo
            assign lower = '0;
        end else begin : g_lo
            assign lower = slot_data[i-1];
        end
        if (i == N - 1) begin : g_hi
            assign upper = '0;
        end else begin : g_hi
            assign upper = slot_data[i+1];
        end
        ilir_cell u_cell (
            .aclk       (aclk),
            .slot_index (ilir_pkg::idx_t'(i)),
            .ctrl       (ctrl),
            .lower_data (lower),
            .upper_data (upper),
            .slot_data  (slot_data[i]),
            .read_data  (read_data[i])
        );
    end

    // only the addressed cell drives a nonzero word
    always_comb begin
        read_bus = '0;
        for (int i = 0; i < N; i++) begin
            read_bus = read_bus | read_data[i];
        end
    end

    always_comb begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            count_next      = result.count_next;
            out_valid_next  = 1'b1;
            out_value_next  = result.read_en ? ilir_pkg::value_t'(read_bus) : '0;
            out_status_next = result.status;
            out_count_next  = ilir_pkg::cfield_t'(result.count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_count_reg, out_status_reg, out_value_reg};

endmodule

// ===== hw/rtl/ilir_cell.sv =====
// ----------------------------------------------------------------------------
// ilir_cell: one list slot
// Holds one element; shifts from its lower or upper neighbor, or loads the
// broadcast value, and drives its element onto the read bus when addressed.
// ----------------------------------------------------------------------------
module ilir_cell (
    input  logic                aclk,
    input  ilir_pkg::idx_t      slot_index,
    input  ilir_pkg::cell_ctrl_t ctrl,
    input  ilir_pkg::data_t     lower_data,
    input  ilir_pkg::data_t     upper_data,
    output ilir_pkg::data_t     slot_data,
    output ilir_pkg::data_t     read_data
);

    ilir_pkg::data_t data_reg;
    ilir_pkg::data_t data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            ilir_pkg::OP_INSERT: begin
                if (slot_index == ctrl.idx) begin
                    data_next = ctrl.data;
                end else if (slot_index > ctrl.idx) begin
                    data_next = lower_data;
                end
            end
            ilir_pkg::OP_REMOVE: begin
                if (slot_index >= ctrl.idx) begin
                    data_next = upper_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign slot_data = data_reg;
    assign read_data = (slot_index == ctrl.idx) ? data_reg : '0;

endmodule

// ===== hw/rtl/ilir_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilir_ctrl: command decode
// Range and full checks, index normalization and the cell control word.
// ----------------------------------------------------------------------------
module ilir_ctrl (
    input  logic                  accept,
    input  ilir_pkg::cmd_t        command,
    input  logic signed [7:0]     position,
    input  ilir_pkg::value_t      item_value,
    input  ilir_pkg::count_t      count,
    output ilir_pkg::cell_ctrl_t  ctrl,
    output ilir_pkg::cmd_result_t result
);

    localparam int SW = ilir_pkg::SIDX_WIDTH;
    localparam int CW = ilir_pkg::COUNT_WIDTH;

    logic signed [SW-1:0] pos_s;
    logic signed [SW-1:0] n_s;
    logic signed [SW-1:0] idx_s;
    logic                 full;
    logic                 ins_ok_range;
    logic                 rd_ok_range;

    always_comb begin
        pos_s        = {{(SW-8){position[7]}}, position};
        n_s          = $signed({{(SW-CW){1'b0}}, count});
        idx_s        = (pos_s < 0) ? (pos_s + n_s) : pos_s;
        full         = (count == CW'(ilir_pkg::CAPACITY));
        ins_ok_range = (pos_s >= 0) && (pos_s <= n_s);
        rd_ok_range  = (pos_s >= -n_s) && (pos_s < n_s);

        ctrl.op   = ilir_pkg::OP_HOLD;
        ctrl.idx  = idx_s[ilir_pkg::IDX_WIDTH-1:0];
        ctrl.data = ilir_pkg::data_t'(item_value);

        result.status     = ilir_pkg::ST_OK;
        result.read_en    = 1'b0;
        result.count_next = count;

        unique case (command)
            ilir_pkg::CMD_APPEND: begin
                // append is an insert at the tail
                ctrl.idx = count[ilir_pkg::IDX_WIDTH-1:0];
                if (full) begin
                    result.status = ilir_pkg::ST_FULL;
                end else begin
                    ctrl.op           = ilir_pkg::OP_INSERT;
                    result.count_next = count + 1'b1;
                end
            end
            ilir_pkg::CMD_INSERT: begin
                if (!ins_ok_range) begin
                    result.status = ilir_pkg::ST_RANGE;
                end else if (full) begin
                    result.status = ilir_pkg::ST_FULL;
                end else begin
                    ctrl.op           = ilir_pkg::OP_INSERT;
                    result.count_next = count + 1'b1;
                end
            end
            ilir_pkg::CMD_GET: begin
                if (!rd_ok_range) begin
                    result.status = ilir_pkg::ST_RANGE;
                end else begin
                    result.read_en = 1'b1;
                end
            end
            ilir_pkg::CMD_REMOVE: begin
                if (!rd_ok_range) begin
                    result.status = ilir_pkg::ST_RANGE;
                end else begin
                    result.read_en    = 1'b1;
                    ctrl.op           = ilir_pkg::OP_REMOVE;
                    result.count_next = count - 1'b1;
                end
            end
            default: begin
                result.status = ilir_pkg::ST_OK;
            end
        endcase

        if (!accept) begin
            ctrl.op = ilir_pkg::OP_HOLD;
        end
    end

endmodule

// ===== test/tb_indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_remove: stream-level test of the indexed list
// Feeds append, insert, get and remove commands, mirrors the list contents in
// a local copy and compares every returned word against the expected value,
// status and count. Both sides stall at random in two of its three phases.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_remove;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1100;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        ilir_pkg::cmd_t     command;
        logic signed [7:0]  position;
        ilir_pkg::value_t   item_value;
        bit                 drain_first;   // wait for all replies before sending
    } list_cmd_t;

    typedef struct {
        ilir_pkg::value_t  read_value;
        ilir_pkg::status_t status;
        ilir_pkg::cfield_t count;
    } list_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    list_cmd_t   pending_cmds[$];
    list_reply_t reply_q[$];
    list_cmd_t   offered_cmd;

    // local copy of the list
    ilir_pkg::data_t list_mem[ilir_pkg::CAPACITY];
    int          list_len = 0;
    int          gen_len = 0;      // element count as tracked while generating

    int          sent_count = 0;
    int          total_items = 1;
    int          mismatch_count = 0;
    bit          word_taken = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    indexed_list_insert_remove uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Applies one command to the local list and returns the reply it gives.
    function automatic list_reply_t apply_list_cmd(list_cmd_t c);
        list_reply_t r;
        int p;
        int n;
        int slot;
        int k;
        r.read_value = '0;
        r.status     = ilir_pkg::ST_OK;
        p = c.position;
        n = list_len;
        case (c.command)
            ilir_pkg::CMD_APPEND: begin
                if (n >= ilir_pkg::CAPACITY) begin
                    r.status = ilir_pkg::ST_FULL;
                end else begin
                    list_mem[n] = ilir_pkg::data_t'(c.item_value);
                    list_len++;
                end
            end
            ilir_pkg::CMD_INSERT: begin
                if (p < 0 || p > n) begin
                    r.status = ilir_pkg::ST_RANGE;
                end else if (n >= ilir_pkg::CAPACITY) begin
                    r.status = ilir_pkg::ST_FULL;
                end else begin
                    for (k = n; k > p; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[p] = ilir_pkg::data_t'(c.item_value);
                    list_len++;
                end
            end
            default: begin
                if (p < -n || p >= n) begin
                    r.status = ilir_pkg::ST_RANGE;
                end else begin
                    slot = (p < 0) ? p + n : p;
                    r.read_value = ilir_pkg::value_t'(list_mem[slot]);
                    if (c.command == ilir_pkg::CMD_REMOVE) begin
                        for (k = slot; k < n - 1; k++)
                            list_mem[k] = list_mem[k+1];
                        list_len--;
                    end
                end
            end
        endcase
        r.count = ilir_pkg::cfield_t'(list_len);
        return r;
    endfunction

    function automatic int idle_pct(bit receiver);
        int phase;
        phase = (sent_count * 3) / total_items;
        if (phase == 0)
            return receiver ? 53 : 30;
        if (phase == 1)
            return receiver ? 30 : 53;
        return 0;
    endfunction

    task automatic add_cmd(ilir_pkg::cmd_t c, int p, ilir_pkg::value_t v, bit drain);
        list_cmd_t w;
        w.command     = c;
        w.position    = p[7:0];
        w.item_value  = v;
        w.drain_first = drain;
        pending_cmds.push_back(w);
        case (c)
            ilir_pkg::CMD_APPEND:
                if (gen_len < ilir_pkg::CAPACITY) gen_len++;
            ilir_pkg::CMD_INSERT:
                if (p >= 0 && p <= gen_len && gen_len < ilir_pkg::CAPACITY) gen_len++;
            ilir_pkg::CMD_REMOVE:
                if (p >= -gen_len && p < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    // Mostly valid indices, some just past either end, some anywhere in 8 bits.
    function automatic int pick_pos(ilir_pkg::cmd_t c);
        logic signed [7:0] any_pos;
        int r;
        int k;
        r = $urandom_range(99);
        any_pos = 8'($urandom);
        if (c == ilir_pkg::CMD_APPEND || r < 8)
            return any_pos;
        if (r < 16) begin
            if (c == ilir_pkg::CMD_INSERT)
                return $urandom_range(1) ? gen_len + 1 : -1;
            return $urandom_range(1) ? gen_len : -gen_len - 1;
        end
        if (c == ilir_pkg::CMD_INSERT)
            return $urandom_range(gen_len, 0);
        if (gen_len == 0)
            return 0;
        if ($urandom_range(1))
            return $urandom_range(gen_len - 1, 0);
        k = $urandom_range(gen_len, 1);
        return -k;
    endfunction

    // stimulus and end of run
    initial begin
        logic signed [7:0] rnd_pos;
        ilir_pkg::cmd_t cmd;
        int   mode;
        int   seg;
        int   j;
        int   r;

        // empty list, boundaries, negative indices
        add_cmd(ilir_pkg::CMD_GET,    0,  32'h1234_5678, 1'b0);
        add_cmd(ilir_pkg::CMD_REMOVE, -1, 32'h0,         1'b0);
        add_cmd(ilir_pkg::CMD_INSERT, 1,  32'hDEAD_BEEF, 1'b0);
        add_cmd(ilir_pkg::CMD_INSERT, -1, 32'hDEAD_BEEF, 1'b0);
        add_cmd(ilir_pkg::CMD_INSERT, 0,  32'hFFFF_FFFF, 1'b0);
        add_cmd(ilir_pkg::CMD_APPEND, 0,  32'h0000_0000, 1'b0);
        add_cmd(ilir_pkg::CMD_INSERT, 1,  $urandom,      1'b0);
        add_cmd(ilir_pkg::CMD_INSERT, 3,  32'hA5A5_A5A5, 1'b0);
        add_cmd(ilir_pkg::CMD_GET,    0,  32'h0,         1'b1);
        add_cmd(ilir_pkg::CMD_GET,    -1, 32'h0,         1'b0);
        add_cmd(ilir_pkg::CMD_GET,    -4, 32'h0,         1'b0);
        add_cmd(ilir_pkg::CMD_GET,    -5, 32'h0,         1'b0);
        add_cmd(ilir_pkg::CMD_GET,    4,  32'h0,         1'b0);
        add_cmd(ilir_pkg::CMD_GET,    127, 32'hFFFF_FFFF, 1'b0);
        add_cmd(ilir_pkg::CMD_REMOVE, -128, 32'h0,       1'b0);
        add_cmd(ilir_pkg::CMD_REMOVE, 1,  32'h0,         1'b0);
        add_cmd(ilir_pkg::CMD_REMOVE, -1, 32'h0,         1'b0);
        add_cmd(ilir_pkg::CMD_GET,    1,  32'h0,         1'b0);
        add_cmd(ilir_pkg::CMD_APPEND, -128, 32'h5A5A_5A5A, 1'b0);
        add_cmd(ilir_pkg::CMD_APPEND, 127,  32'hC3C3_3C3C, 1'b0);

        // fill up, then hit the full list
        while (gen_len < ilir_pkg::CAPACITY) begin
            rnd_pos = 8'($urandom);
            add_cmd(ilir_pkg::CMD_APPEND, rnd_pos, $urandom, 1'b0);
        end
        add_cmd(ilir_pkg::CMD_APPEND, 0,  32'hFFFF_FFFF, 1'b0);
        add_cmd(ilir_pkg::CMD_INSERT, 5,  32'h1111_1111, 1'b0);
        // range wins over full
        add_cmd(ilir_pkg::CMD_INSERT, ilir_pkg::CAPACITY + 1, 32'h2222_2222, 1'b0);
        add_cmd(ilir_pkg::CMD_INSERT, -1, 32'h3333_3333, 1'b0);
        add_cmd(ilir_pkg::CMD_GET,    -ilir_pkg::CAPACITY, 32'h0, 1'b0);
        add_cmd(ilir_pkg::CMD_GET,    ilir_pkg::CAPACITY - 1, 32'h0, 1'b0);
        add_cmd(ilir_pkg::CMD_GET,    ilir_pkg::CAPACITY, 32'h0, 1'b0);
        add_cmd(ilir_pkg::CMD_REMOVE, 0,  32'h0, 1'b0);
        add_cmd(ilir_pkg::CMD_INSERT, 0,  $urandom, 1'b0);
        add_cmd(ilir_pkg::CMD_REMOVE, -ilir_pkg::CAPACITY, 32'h0, 1'b0);

        // random segments that lean toward filling, draining, or neither
        while (pending_cmds.size() < ITEM_TARGET) begin
            mode = $urandom_range(2);
            seg  = $urandom_range(120, 20);
            for (j = 0; j < seg; j++) begin
                r = $urandom_range(99);
                if (mode == 0)
                    cmd = (r < 45) ? ilir_pkg::CMD_APPEND :
                          (r < 75) ? ilir_pkg::CMD_INSERT :
                          (r < 88) ? ilir_pkg::CMD_GET : ilir_pkg::CMD_REMOVE;
                else if (mode == 1)
                    cmd = (r < 10) ? ilir_pkg::CMD_APPEND :
                          (r < 20) ? ilir_pkg::CMD_INSERT :
                          (r < 40) ? ilir_pkg::CMD_GET : ilir_pkg::CMD_REMOVE;
                else
                    cmd = ilir_pkg::cmd_t'($urandom_range(3));
                add_cmd(cmd, pick_pos(cmd), $urandom,
                        (j == 0) && ($urandom_range(3) == 0));
            end
        end
        total_items = pending_cmds.size();
        pending_cmds[total_items / 3].drain_first = 1'b1;
        pending_cmds[2 * total_items / 3].drain_first = 1'b1;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (sent_count < total_items) @(posedge aclk);
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // command driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (pending_cmds.size() == 0 ||
                (pending_cmds[0].drain_first && reply_q.size() != 0) ||
                $urandom_range(99) < idle_pct(1'b0)) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                offered_cmd = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, offered_cmd.item_value, offered_cmd.position,
                                  offered_cmd.command};
            end
        end
    end

    // reply receiver, with one long hold-off to back up the input
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_count >= 200) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // input words update the local list; reply words are checked in order
    always @(posedge aclk) begin
        list_reply_t want;
        if (!aresetn) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                reply_q.push_back(apply_list_cmd(offered_cmd));
                sent_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: reply word with none expected, actual %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.read_value) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, m_axis_tdata[31:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[33:32] !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_axis_tdata[33:32]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[40:34] !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, m_axis_tdata[40:34]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_cell.sv
hw/rtl/ilir_ctrl.sv
hw/rtl/indexed_list_insert_remove.sv
test/tb_indexed_list_insert_remove.sv
